>>> hdl/mbrf_pkg.sv
// ----------------------------------------------------------------------------
// mbrf_pkg
// Shared types, codes and helpers for the Modbus RTU request framer.
// ----------------------------------------------------------------------------
package mbrf_pkg;

    // Input operation codes
    localparam logic [2:0] OP_READ        = 3'd0;
    localparam logic [2:0] OP_WRITE_MULTI = 3'd1;
    localparam logic [2:0] OP_CUST_WRITE  = 3'd2;
    localparam logic [2:0] OP_CUST_READ   = 3'd3;
    localparam logic [2:0] OP_DATA        = 3'd4;

    // Modbus function codes placed in the frame
    localparam logic [7:0] FC_READ_HOLDING = 8'h03;
    localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;
    localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] BYTE_ZERO       = 8'h00;

    // CRC-16/MODBUS
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef logic [2:0] t_byte_idx;

    // Fold one byte into the running CRC, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // Pick the payload byte at a given position of the frame segment
    function automatic logic [7:0] payload_byte(input logic [2:0]  op,
                                                input t_byte_idx   idx,
                                                input logic [7:0]  slave_addr,
                                                input logic [15:0] reg_addr,
                                                input logic [7:0]  count,
                                                input logic [15:0] word);
        logic [7:0] b;
        b = BYTE_ZERO;
        if (op == OP_DATA) begin
            b = idx[0] ? word[7:0] : word[15:8];
        end else begin
            unique case (idx)
                3'd0: b = slave_addr;
                3'd1: begin
                    if (op == OP_WRITE_MULTI) begin
                        b = FC_WRITE_MULTI;
                    end else if (op == OP_CUST_WRITE) begin
                        b = FC_WRITE_SINGLE;
                    end else begin
                        b = FC_READ_HOLDING;
                    end
                end
                3'd2: b = reg_addr[15:8];
                3'd3: b = reg_addr[7:0];
                3'd4: b = (op == OP_CUST_WRITE) ? count : BYTE_ZERO;
                3'd5: b = count;
                3'd6: b = {count[6:0], 1'b0};
                default: b = BYTE_ZERO;
            endcase
        end
        return b;
    endfunction

endpackage

>>> hdl/mbrf_stream_if.sv
// ----------------------------------------------------------------------------
// mbrf_req_if / mbrf_byte_if
// Valid/ready channels for framer requests and outgoing frame bytes.
// ----------------------------------------------------------------------------
interface mbrf_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [7:0]  slave_addr;
    logic [15:0] reg_addr;
    logic [7:0]  count;
    logic [15:0] word;

    modport source (output valid, op, slave_addr, reg_addr, count, word, input ready);
    modport sink   (input valid, op, slave_addr, reg_addr, count, word, output ready);
endinterface

interface mbrf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       last;
    logic       frame_end;
    logic       error;

    modport source (output valid, tx_byte, last, frame_end, error, input ready);
    modport sink   (input valid, tx_byte, last, frame_end, error, output ready);
endinterface

>>> hdl/modbus_rtu_request_framer_core.sv
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer_core
// Serialises Modbus RTU request frames and appends the CRC-16/MODBUS.
// ----------------------------------------------------------------------------
// Each request transaction is taken in and then gives out its frame bytes one
// per cycle as long as the byte sink keeps up. A single byte-wide CRC unit
// folds one payload byte per cycle while a small sequencer walks the byte
// positions; the request side is not ready until the last byte of a
// transaction has been loaded into the output register, and unused op codes
// are dropped at once.
module modbus_rtu_request_framer_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mbrf_req_if.sink     i_req,
    mbrf_byte_if.source  o_frm
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SEND = 1'b1;

    logic                r_state, n_state;
    logic [2:0]          r_op;
    logic [7:0]          r_addr;
    logic [15:0]         r_reg;
    logic [7:0]          r_cnt;
    logic [15:0]         r_word;
    mbrf_pkg::t_byte_idx r_idx;
    mbrf_pkg::t_byte_idx r_last_idx;
    logic [2:0]          r_npay;
    logic                r_err;
    logic                r_end_clr;
    logic [15:0]         r_crc;
    logic [7:0]          r_words_left;

    logic                r_out_valid;
    logic [7:0]          r_tx_byte;
    logic                r_last;
    logic                r_frame_end;
    logic                r_error;

    logic                accept;
    logic                out_free;
    logic                step;
    logic                is_header;
    logic                in_payload;
    logic [7:0]          pay_byte;
    logic [7:0]          cur_byte;
    logic [2:0]          new_npay;
    logic                new_crc_on;
    logic                new_err;

    assign i_req.ready = (r_state == ST_IDLE);
    assign accept      = i_req.valid && (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || o_frm.ready;
    assign step        = (r_state == ST_SEND) && out_free;
    assign is_header   = (i_req.op == mbrf_pkg::OP_READ) ||
                         (i_req.op == mbrf_pkg::OP_WRITE_MULTI) ||
                         (i_req.op == mbrf_pkg::OP_CUST_WRITE) ||
                         (i_req.op == mbrf_pkg::OP_CUST_READ);

    // Work out the shape of the segment a new transaction produces
    always_comb begin
        new_npay   = 3'd0;
        new_crc_on = 1'b0;
        new_err    = 1'b0;
        unique case (i_req.op)
            mbrf_pkg::OP_READ: begin
                new_npay   = 3'd6;
                new_crc_on = 1'b1;
            end
            mbrf_pkg::OP_WRITE_MULTI: begin
                new_npay   = 3'd7;
            end
            mbrf_pkg::OP_CUST_WRITE: begin
                new_npay   = 3'd5;
                new_crc_on = (i_req.count == 8'd0);
            end
            mbrf_pkg::OP_CUST_READ: begin
                new_npay   = 3'd5;
                new_crc_on = 1'b1;
            end
            mbrf_pkg::OP_DATA: begin
                if (r_words_left == 8'd0) begin
                    new_npay = 3'd1;
                    new_err  = 1'b1;
                end else begin
                    new_npay   = 3'd2;
                    new_crc_on = (r_words_left == 8'd1);
                end
            end
            default: begin
                new_npay = 3'd0;
            end
        endcase
    end

    // Select the byte for the current position
    assign in_payload = (r_idx < r_npay);
    assign pay_byte   = mbrf_pkg::payload_byte(r_op, r_idx, r_addr, r_reg, r_cnt, r_word);

    always_comb begin
        priority if (r_err) begin
            cur_byte = mbrf_pkg::BYTE_ZERO;
        end else if (in_payload) begin
            cur_byte = pay_byte;
        end else if (r_idx == r_npay) begin
            cur_byte = r_crc[7:0];
        end else begin
            cur_byte = r_crc[15:8];
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (is_header || (i_req.op == mbrf_pkg::OP_DATA))) begin
                    n_state = ST_SEND;
                end
            end
            ST_SEND: begin
                if (step && (r_idx == r_last_idx)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Latch the transaction and advance the byte position
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= i_req.op;
            r_addr     <= i_req.slave_addr;
            r_reg      <= i_req.reg_addr;
            r_cnt      <= i_req.count;
            r_word     <= i_req.word;
            r_idx      <= '0;
            r_npay     <= new_npay;
            r_err      <= new_err;
            r_last_idx <= new_npay - 3'd1 + (new_crc_on ? 3'd2 : 3'd0);
            r_end_clr  <= new_crc_on ||
                          ((i_req.op == mbrf_pkg::OP_WRITE_MULTI) && (i_req.count == 8'd0));
        end else if (step) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    // Running CRC and outstanding word count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc        <= mbrf_pkg::CRC_INIT;
            r_words_left <= 8'd0;
        end else if (accept) begin
            if (is_header) begin
                r_crc <= mbrf_pkg::CRC_INIT;
                if ((i_req.op == mbrf_pkg::OP_WRITE_MULTI) ||
                    (i_req.op == mbrf_pkg::OP_CUST_WRITE)) begin
                    r_words_left <= i_req.count;
                end else begin
                    r_words_left <= 8'd0;
                end
            end else if ((i_req.op == mbrf_pkg::OP_DATA) && (r_words_left != 8'd0)) begin
                r_words_left <= r_words_left - 8'd1;
            end
        end else if (step) begin
            if ((r_idx == r_last_idx) && r_end_clr) begin
                r_crc <= mbrf_pkg::CRC_INIT;
            end else if (!r_err && in_payload) begin
                r_crc <= mbrf_pkg::crc_byte(r_crc, cur_byte);
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_frm.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_tx_byte   <= cur_byte;
            r_last      <= (r_idx == r_last_idx);
            r_frame_end <= !r_err && !in_payload && (r_idx != r_npay);
            r_error     <= r_err;
        end
    end

    assign o_frm.valid     = r_out_valid;
    assign o_frm.tx_byte   = r_tx_byte;
    assign o_frm.last      = r_last;
    assign o_frm.frame_end = r_frame_end;
    assign o_frm.error     = r_error;

endmodule

>>> hdl/mbrf_checker.sv
// ----------------------------------------------------------------------------
// mbrf_checker
// Port-level checks on the Modbus RTU request framer, bound to the top level.
// ----------------------------------------------------------------------------
module mbrf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic [2:0]  i_req_op,
    input logic        i_frm_valid,
    input logic        i_frm_ready,
    input logic [7:0]  i_frm_tx_byte,
    input logic        i_frm_last,
    input logic        i_frm_frame_end,
    input logic        i_frm_error
);

    // A valid request keeps the sequencer busy on the next cycle
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready && (i_req_op <= mbrf_pkg::OP_DATA)) |=> !i_req_ready)
        else $error("framer ready straight after taking a request");

    // An error byte stands alone, carries zero and closes no frame
    a_error_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_frm_valid && i_frm_error) |->
        ((i_frm_tx_byte == 8'h00) && i_frm_last && !i_frm_frame_end))
        else $error("malformed error byte");

    // The closing CRC byte is always the last byte of its transaction
    a_frame_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_frm_valid && i_frm_frame_end) |-> i_frm_last)
        else $error("frame end not on the last byte");

    // Hold a stalled output byte
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_frm_valid && !i_frm_ready) |=> (i_frm_valid && $stable(i_frm_tx_byte)))
        else $error("stalled output byte changed");

endmodule

bind modbus_rtu_request_framer_core mbrf_checker u_mbrf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_req_op        (i_req.op),
    .i_frm_valid     (o_frm.valid),
    .i_frm_ready     (o_frm.ready),
    .i_frm_tx_byte   (o_frm.tx_byte),
    .i_frm_last      (o_frm.last),
    .i_frm_frame_end (o_frm.frame_end),
    .i_frm_error     (o_frm.error)
);
